FILE: design/ivs_pkg.sv
// shared constants, codes and control types for the indexed vector store
package ivs_pkg;

    localparam int CAPACITY  = 256;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int IDX_W     = 10;
    localparam int WORD_W    = 32;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 56;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT,
        ST_TOP,
        ST_SCAN,
        ST_FINISH
    } ivs_state_t;

    typedef struct packed {
        logic load_req;
        logic clr_step;
        logic do_insert;
        logic rd_req;
        logic shift_start;
        logic shift_step;
        logic top_fill;
        logic scan_step;
        logic finish;
    } ivs_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       idx_hit;
        logic       clear_last;
        logic       shift_more;
        logic       scan_done;
        logic       out_free;
    } ivs_stat_t;

endpackage

FILE: design/ivs_dp.sv
// datapath of the indexed vector store: request registers, counters, entry memory, output word
module ivs_dp
    import ivs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    input  ivs_cmd_t            cmd,
    output ivs_stat_t           stat
);

    localparam logic [IDX_W-1:0] CAP_IDX  = IDX_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAPACITY - 1);

    logic [WORD_W-1:0]   mem [CAPACITY];

    logic [1:0]          act_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WORD_W-1:0]   val_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    alloc_reg;
    logic [CNT_W-1:0]    ptr_reg;
    logic [ADDR_W-1:0]   wa_reg;
    logic                pend_reg;
    logic [WORD_W-1:0]   rdata_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                idx_hit;
    logic                insert_bad;
    logic [IDX_W-1:0]    grown_wide;
    logic [CNT_W-1:0]    grown;
    logic                scan_hit;
    logic                shift_more;
    logic [CNT_W-1:0]    ptr_m1;
    logic [CNT_W-1:0]    alloc_m1;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                is_read_hit;
    logic                is_err;

    assign idx_hit    = idx_reg < {1'b0, alloc_reg};
    assign insert_bad = idx_reg >= CAP_IDX;
    // 2*index+1, only used when index is below capacity
    assign grown_wide = {idx_reg[IDX_W-2:0], 1'b1};
    assign grown      = (grown_wide > CAP_IDX) ? CAP_CNT : grown_wide[CNT_W-1:0];
    assign scan_hit   = pend_reg && (rdata_reg != EMPTY_WORD);
    assign shift_more = ptr_reg < alloc_reg;
    assign ptr_m1     = ptr_reg - 1'b1;
    assign alloc_m1   = alloc_reg - 1'b1;

    assign is_read_hit = (act_reg == ACT_READ) && idx_hit;
    assign is_err      = (act_reg == ACT_INSERT) && insert_bad;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[ADDR_W-1:0];
        mem_wdata = EMPTY_WORD;
        priority if (cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (cmd.do_insert) begin
            mem_we    = !insert_bad;
            mem_waddr = idx_reg[ADDR_W-1:0];
            mem_wdata = val_reg;
        end else if (cmd.shift_step) begin
            // move the word read last cycle one place down
            mem_we    = pend_reg;
            mem_waddr = wa_reg;
            mem_wdata = rdata_reg;
        end else if (cmd.top_fill) begin
            mem_we    = 1'b1;
            mem_waddr = alloc_m1[ADDR_W-1:0];
        end else begin
            mem_we = 1'b0;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = ptr_reg[ADDR_W-1:0];
        priority if (cmd.rd_req) begin
            mem_re    = 1'b1;
            mem_raddr = idx_reg[ADDR_W-1:0];
        end else if (cmd.shift_step) begin
            mem_re = shift_more;
        end else if (cmd.scan_step) begin
            mem_re    = !scan_hit && (ptr_reg != '0);
            mem_raddr = ptr_m1[ADDR_W-1:0];
        end else begin
            mem_re = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            act_reg <= s_tdata[1:0];
            idx_reg <= s_tdata[IDX_W+1:2];
            val_reg <= s_tdata[IDX_W+WORD_W+1:IDX_W+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            alloc_reg <= '0;
            ptr_reg   <= '0;
            wa_reg    <= '0;
            pend_reg  <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.do_insert && !insert_bad) begin
                if (!idx_hit) begin
                    alloc_reg <= grown;
                end
                if (idx_reg >= {1'b0, used_reg}) begin
                    used_reg <= idx_reg[CNT_W-1:0] + 1'b1;
                end
            end
            if (cmd.shift_start) begin
                ptr_reg  <= idx_reg[CNT_W-1:0] + 1'b1;
                pend_reg <= 1'b0;
            end
            if (cmd.shift_step) begin
                if (shift_more) begin
                    wa_reg   <= ptr_m1[ADDR_W-1:0];
                    pend_reg <= 1'b1;
                    ptr_reg  <= ptr_reg + 1'b1;
                end else begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.top_fill) begin
                alloc_reg <= alloc_m1;
                ptr_reg   <= alloc_m1;
                used_reg  <= '0;
                pend_reg  <= 1'b0;
            end
            if (cmd.scan_step) begin
                // rescan downward, one read in flight
                if (scan_hit) begin
                    used_reg <= {1'b0, wa_reg} + 1'b1;
                    pend_reg <= 1'b0;
                end else if (ptr_reg != '0) begin
                    wa_reg   <= ptr_m1[ADDR_W-1:0];
                    pend_reg <= 1'b1;
                    ptr_reg  <= ptr_m1;
                end else begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {4'b0, alloc_reg, used_reg, is_err, is_read_hit,
                             is_read_hit ? rdata_reg : '0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.act        = act_reg;
    assign stat.idx_hit    = idx_hit;
    assign stat.clear_last = ptr_reg == LAST_CNT;
    assign stat.shift_more = shift_more;
    assign stat.scan_done  = scan_hit || (ptr_reg == '0);
    assign stat.out_free   = !out_valid_reg || m_tready;

endmodule

FILE: design/ivs_ctrl.sv
// controller state machine of the indexed vector store
module ivs_ctrl
    import ivs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ivs_stat_t stat,
    output ivs_cmd_t  cmd
);

    ivs_state_t state_reg;
    ivs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                unique case (stat.act)
                    ACT_INSERT: cmd.do_insert = 1'b1;
                    ACT_READ:   cmd.rd_req = stat.idx_hit;
                    ACT_REMOVE: begin
                        if (stat.idx_hit) begin
                            cmd.shift_start = 1'b1;
                            state_next      = ST_SHIFT;
                        end
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (!stat.shift_more) begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP: begin
                cmd.top_fill = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: design/indexed_vector_store_top.sv
// Indexed vector store of 256 signed 32-bit entries. After reset the block runs a
// clearing pass that sets every entry to -1 before it takes the first word. It then
// works on one request at a time: an insert or a read passes through the decode and
// finish states, a remove at index i with allocated size A shifts the later entries
// down through the entry memory, one read and one write per cycle, fills the top
// slot and rescans downward for the last used entry. The result word sits in an
// output register, so the next request is taken while it waits on m_tready.
module indexed_vector_store_top
    import ivs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // action[1:0], index[11:2], value[43:12], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_value[31:0], found[32], error[33], used_size[42:34],
    // allocated_size[51:43], zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    ivs_cmd_t  cmd;
    ivs_stat_t stat;

    ivs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ivs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the indexed vector store: directed table, then random traffic
module tb_top;
    import ivs_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int DIR_N          = 25;
    localparam int RAND_ITEMS     = 2000;
    localparam int HOLD_CYCLES    = 600;
    localparam int TAIL_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic [1:0]        act;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] rd_val;
        logic              found;
        logic              err;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  alloc;
    } resp_t;

    typedef struct packed {
        req_t  req;
        logic  typed;
        resp_t rsp;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    indexed_vector_store_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow copy of the store
    logic [WORD_W-1:0] shadow_mem [CAPACITY];
    int                shadow_used;
    int                shadow_alloc;

    resp_t    pending_resp_q [$];
    dir_row_t dir_tab [DIR_N];
    int       mismatch_cnt;
    int       burst_left;
    bit       steady;
    bit       hold_req;
    int       hold_left;
    int       rx_mode;
    int       rx_mode_left;
    logic [31:0] stall_pat;
    logic     rx_rdy;
    int       idle_cycles;
    resp_t    want_rsp;
    resp_t    got_rsp;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic resp_t vec_store_response(req_t r);
        resp_t rsp;
        int    i;
        int    ix;
        rsp = '0;
        ix  = int'(r.idx);
        case (r.act)
            ACT_INSERT: begin
                if (ix >= CAPACITY) begin
                    rsp.err = 1'b1;
                end else begin
                    if (ix >= shadow_alloc)
                        shadow_alloc = (2 * ix + 1 > CAPACITY) ? CAPACITY : 2 * ix + 1;
                    if (ix >= shadow_used)
                        shadow_used = ix + 1;
                    shadow_mem[ix] = r.val;
                end
            end
            ACT_READ: begin
                if (ix < shadow_alloc) begin
                    rsp.rd_val = shadow_mem[ix];
                    rsp.found  = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (ix < shadow_alloc) begin
                    for (i = ix; i + 1 < shadow_alloc; i++)
                        shadow_mem[i] = shadow_mem[i + 1];
                    shadow_mem[shadow_alloc - 1] = EMPTY_WORD;
                    shadow_alloc--;
                    shadow_used = 0;
                    // last slot not holding the empty marker
                    for (i = shadow_alloc; i > 0 && shadow_used == 0; i--)
                        if (shadow_mem[i - 1] != EMPTY_WORD)
                            shadow_used = i;
                end
            end
            default: ;
        endcase
        rsp.used  = shadow_used[CNT_W-1:0];
        rsp.alloc = shadow_alloc[CNT_W-1:0];
        return rsp;
    endfunction

    task automatic push_request(input req_t r, input bit typed, input resp_t typed_rsp);
        resp_t p;
        int    gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {{(S_DATA_W - 2 - IDX_W - WORD_W){1'b0}}, r.val, r.idx, r.act};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = vec_store_response(r);
        pending_resp_q.push_back(typed ? typed_rsp : p);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_resp_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return EMPTY_WORD;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        req_t rq;
        int   n_sent;
        int   span;
        int   ep_len;
        int   k;
        int   pick;
        int   lim;
        int   hi;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        hold_req = 1'b0;
        mismatch_cnt = 0;
        burst_left = 0;
        steady = 1'b0;
        shadow_used = 0;
        shadow_alloc = 0;
        for (k = 0; k < CAPACITY; k++)
            shadow_mem[k] = EMPTY_WORD;

        dir_tab = '{
            '{'{ACT_READ,    10'd0,    32'd0},        1'b1, '{32'd0, 1'b0, 1'b0, 9'd0, 9'd0}},
            '{'{ACT_REMOVE,  10'd0,    32'd0},        1'b1, '{32'd0, 1'b0, 1'b0, 9'd0, 9'd0}},
            '{'{ACT_UNKNOWN, 10'd5,    32'd0},        1'b1, '{32'd0, 1'b0, 1'b0, 9'd0, 9'd0}},
            '{'{ACT_INSERT,  10'd1023, 32'd7},        1'b1, '{32'd0, 1'b0, 1'b1, 9'd0, 9'd0}},
            '{'{ACT_INSERT,  10'd256,  32'd9},        1'b1, '{32'd0, 1'b0, 1'b1, 9'd0, 9'd0}},
            '{'{ACT_INSERT,  10'd0,    32'h7FFF_FFFF}, 1'b1, '{32'd0, 1'b0, 1'b0, 9'd1, 9'd1}},
            '{'{ACT_INSERT,  10'd3,    32'h8000_0000}, 1'b1, '{32'd0, 1'b0, 1'b0, 9'd4, 9'd7}},
            '{'{ACT_READ,    10'd3,    32'd0},
              1'b1, '{32'h8000_0000, 1'b1, 1'b0, 9'd4, 9'd7}},
            // inside the allocation but past the last used slot
            '{'{ACT_READ,    10'd5,    32'd0},
              1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 9'd4, 9'd7}},
            '{'{ACT_READ,    10'd7,    32'd0},        1'b1, '{32'd0, 1'b0, 1'b0, 9'd4, 9'd7}},
            '{'{ACT_INSERT,  10'd2,    32'hFFFF_FFFF}, 1'b0, '0},
            '{'{ACT_INSERT,  10'd255,  32'd1234},
              1'b1, '{32'd0, 1'b0, 1'b0, 9'd256, 9'd256}},
            '{'{ACT_READ,    10'd255,  32'd0},        1'b0, '0},
            '{'{ACT_REMOVE,  10'd255,  32'd0},        1'b0, '0},
            '{'{ACT_INSERT,  10'd254,  32'd0},        1'b0, '0},
            '{'{ACT_REMOVE,  10'd0,    32'd0},        1'b0, '0},
            '{'{ACT_READ,    10'd0,    32'd0},        1'b0, '0},
            '{'{ACT_REMOVE,  10'd3,    32'd0},        1'b0, '0},
            '{'{ACT_UNKNOWN, 10'd1023, 32'hFFFF_FFFF}, 1'b0, '0},
            '{'{ACT_INSERT,  10'd128,  32'h5555_5555}, 1'b0, '0},
            '{'{ACT_REMOVE,  10'd300,  32'd0},        1'b0, '0},
            '{'{ACT_READ,    10'd1023, 32'd0},        1'b0, '0},
            // a stored -1 below the last used slot, then a remove and a rescan
            '{'{ACT_INSERT,  10'd200,  32'hFFFF_FFFF}, 1'b0, '0},
            '{'{ACT_REMOVE,  10'd0,    32'd0},        1'b0, '0},
            '{'{ACT_READ,    10'd511,  32'hAAAA_AAAA}, 1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIR_N; k++)
            push_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);

        // sender waits for everything, then the receiver holds off while words pile up
        drain_results();
        hold_req = 1'b1;
        steady = 1'b1;
        for (k = 0; k < 24; k++) begin
            rq.act = (k % 3 == 0) ? ACT_INSERT : ACT_READ;
            rq.idx = IDX_W'($urandom_range(0, 15));
            rq.val = $urandom;
            push_request(rq, 1'b0, '0);
        end

        n_sent = 0;
        while (n_sent < RAND_ITEMS) begin
            span   = ($urandom_range(0, 7) == 0) ? CAPACITY : $urandom_range(2, 24);
            ep_len = $urandom_range(20, 80);
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                drain_results();
            if ($urandom_range(0, 11) == 0)
                hold_req = 1'b1;

            // shrink toward the episode span with cheap removes near the top
            while (shadow_alloc > span) begin
                lim    = (shadow_alloc > 4) ? 3 : shadow_alloc - 1;
                rq.act = ACT_REMOVE;
                rq.idx = IDX_W'(shadow_alloc - 1 - int'($urandom_range(0, lim)));
                rq.val = $urandom;
                push_request(rq, 1'b0, '0);
                n_sent++;
            end

            for (k = 0; k < ep_len; k++) begin
                pick   = $urandom_range(0, 99);
                rq.val = pick_word();
                if (pick < 40) begin
                    rq.act = ACT_INSERT;
                    if (shadow_alloc > 0 && $urandom_range(0, 1) == 0)
                        rq.idx = IDX_W'($urandom_range(0, shadow_alloc - 1));
                    else
                        rq.idx = IDX_W'($urandom_range(0, (span - 1) / 2));
                end else if (pick < 70) begin
                    rq.act = ACT_READ;
                    rq.idx = IDX_W'($urandom_range(0, shadow_alloc + 2));
                end else if (pick < 88) begin
                    rq.act = ACT_REMOVE;
                    rq.idx = IDX_W'($urandom_range(0, shadow_alloc));
                end else if (pick < 94) begin
                    rq.act = ACT_INSERT;
                    rq.idx = IDX_W'($urandom_range(CAPACITY, 1023));
                end else if (pick < 97) begin
                    rq.act = ACT_UNKNOWN;
                    rq.idx = IDX_W'($urandom_range(0, 1023));
                end else begin
                    rq.act = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_REMOVE;
                    hi     = 1023;
                    rq.idx = IDX_W'($urandom_range(0, hi));
                end
                push_request(rq, 1'b0, '0);
                if (rq.act != ACT_UNKNOWN)
                    n_sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_resp_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver: long hold-offs on request, otherwise its own stall pattern
    initial begin
        m_tready <= 1'b0;
        hold_left = 0;
        rx_mode_left = 0;
        rx_mode = 0;
        stall_pat = '1;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rx_rdy = 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(16, 200);
                    stall_pat    = $urandom | 32'h1;
                end
                rx_mode_left--;
                case (rx_mode)
                    0: rx_rdy = 1'b1;
                    1: begin
                        rx_rdy    = stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[31:1]};
                    end
                    default: rx_rdy = ($urandom_range(0, 3) != 0);
                endcase
            end
            m_tready <= rx_rdy;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rsp.rd_val = m_tdata[31:0];
            got_rsp.found  = m_tdata[32];
            got_rsp.err    = m_tdata[33];
            got_rsp.used   = m_tdata[42:34];
            got_rsp.alloc  = m_tdata[51:43];
            if (pending_resp_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata);
                mismatch_cnt++;
            end else begin
                want_rsp = pending_resp_q.pop_front();
                check_field("read_value", want_rsp.rd_val, got_rsp.rd_val);
                check_field("found", 32'(want_rsp.found), 32'(got_rsp.found));
                check_field("error", 32'(want_rsp.err), 32'(got_rsp.err));
                check_field("used_size", 32'(want_rsp.used), 32'(got_rsp.used));
                check_field("allocated_size", 32'(want_rsp.alloc), 32'(got_rsp.alloc));
            end
        end
    end

    // watchdog on cycles without any handshake while work is outstanding
    initial idle_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (s_tvalid || pending_resp_q.size() != 0) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
